FILE: rtl/ssed_pkg.sv
// Shared types and codes for the event-stream decoder.
`default_nettype none

package ssed_pkg;

  // Default event name buffer depth in bytes
  localparam int EVENT_MAX_DEF = 32;

  // Input operation codes
  localparam logic OP_EOI = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_FEND  = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] text_byte;
  } ssed_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       event_truncated;
    logic       last;
  } ssed_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the input beat into the item register
    logic sel_second;  // current step is the byte after a replayed CR
    logic act;         // commit the current step
    logic drain_take;  // issue one frame drain beat
  } ssed_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic want_out;    // current step produces a result
    logic more_cr;     // current step replays a CR, the byte follows
    logic go_drain;    // current step closes a frame
    logic frame_done;  // drain has reached the frame end beat
    logic slot_free;   // output register can take a beat
  } ssed_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ssed_ctrl.sv
// Controller for the event-stream decoder: step sequencing and input handshake.
`default_nettype none

module ssed_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ssed_pkg::ssed_stat_t st,
  output ssed_pkg::ssed_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_FIRST,
    ST_SECOND,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   go;
  logic   done_now;
  logic   in_ready;

  // Sequence the steps of the held item
  always_comb begin
    go         = !st.want_out || st.slot_free;
    cmd        = '0;
    done_now   = 1'b0;
    state_nxt  = state_r;
    cmd.sel_second = (state_r == ST_SECOND);
    unique case (state_r)
      ST_EMPTY: begin
        done_now = 1'b1;
      end
      ST_FIRST: begin
        if (go) begin
          cmd.act = 1'b1;
          if (st.more_cr) begin
            state_nxt = ST_SECOND;
          end else if (st.go_drain) begin
            state_nxt = ST_DRAIN;
          end else begin
            done_now = 1'b1;
          end
        end
      end
      ST_SECOND: begin
        if (go) begin
          cmd.act  = 1'b1;
          done_now = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (st.slot_free) begin
          cmd.drain_take = 1'b1;
          done_now       = st.frame_done;
        end
      end
      default: begin
        done_now = 1'b1;
      end
    endcase
    in_ready = rst_n && done_now;
    cmd.load = in_valid && in_ready;
    if (done_now) begin
      state_nxt = cmd.load ? ST_FIRST : ST_EMPTY;
    end
  end

  assign in_stall = !in_ready;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssed_dp.sv
// Datapath for the event-stream decoder: line parser, event name store, output register.
`default_nettype none

module ssed_dp #(
  parameter int EVENT_MAX = ssed_pkg::EVENT_MAX_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ssed_pkg::ssed_cmd_t cmd,
  output ssed_pkg::ssed_stat_t     st,
  input  wire ssed_pkg::ssed_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ssed_pkg::ssed_out_t      out_data
);

  localparam int AW = (EVENT_MAX > 1) ? $clog2(EVENT_MAX) : 1;
  localparam int LW = $clog2(EVENT_MAX + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(EVENT_MAX);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_START,
    PH_NAME,
    PH_VALUE,
    PH_COMMENT
  } phase_t;

  typedef enum logic [1:0] {
    LK_OTHER,
    LK_DATA,
    LK_EVENT
  } lkind_t;

  // Letters of the two field names that matter
  function automatic logic [7:0] data_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h64;  // d
      3'd1:    ch = 8'h61;  // a
      3'd2:    ch = 8'h74;  // t
      3'd3:    ch = 8'h61;  // a
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] event_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h65;  // e
      3'd1:    ch = 8'h76;  // v
      3'd2:    ch = 8'h65;  // e
      3'd3:    ch = 8'h6E;  // n
      3'd4:    ch = 8'h74;  // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Held item
  logic       item_op_r;
  logic [7:0] item_byte_r;

  // Line and frame state
  phase_t         phase_r, phase_nxt, phase_s;
  logic [2:0]     prog_r, prog_nxt, prog_s;
  logic [1:0]     cand_r, cand_nxt, cand_s;     // bit 0: data, bit 1: event
  lkind_t         lkind_r, lkind_nxt, lkind_s;
  logic           space_r, space_nxt, space_s;
  logic           cr_r, cr_nxt, cr_s;
  logic           fopen_r, fopen_nxt, fopen_s;
  logic           dseen_r, dseen_nxt, dseen_s;
  logic [LW-1:0]  len_r, len_nxt, len_s;
  logic           ovf_r, ovf_nxt, ovf_s;
  logic [LW-1:0]  didx_r, didx_nxt;

  // Event name store
  logic [7:0]     ev_mem [EVENT_MAX];
  logic [7:0]     rd_data_r;
  logic [AW-1:0]  rd_addr;

  // Output register
  logic                out_vld_r, out_vld_nxt;
  ssed_pkg::ssed_out_t out_pay_r, out_pay_nxt;

  // Step signals
  logic [7:0] cc;
  logic       is_eoi;
  logic       do_cont;
  logic       do_lreset;
  logic       bf_en;
  lkind_t     bf_kind;
  lkind_t     nkind;
  logic       more_cr;
  logic       go_drain;
  logic       emit;
  logic [1:0] emit_kind;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic       we;
  logic [1:0] fd_cand;
  logic [2:0] fd_prog;
  logic       frame_done;
  logic       slot_free;

  // Name classification from the bytes seen so far
  always_comb begin
    priority if (cand_r[0] && prog_r == 3'd4) begin
      nkind = LK_DATA;
    end else if (cand_r[1] && prog_r == 3'd5) begin
      nkind = LK_EVENT;
    end else begin
      nkind = LK_OTHER;
    end
  end

  // Advance the name matcher by one byte
  always_comb begin
    fd_cand = cand_r;
    if (prog_r >= 3'd4 || cc != data_char(prog_r)) begin
      fd_cand[0] = 1'b0;
    end
    if (prog_r >= 3'd5 || cc != event_char(prog_r)) begin
      fd_cand[1] = 1'b0;
    end
    fd_prog = (prog_r < 3'd7) ? prog_r + 3'd1 : prog_r;
  end

  // Work out the outcome of the current step
  always_comb begin
    phase_s   = phase_r;
    prog_s    = prog_r;
    cand_s    = cand_r;
    lkind_s   = lkind_r;
    space_s   = space_r;
    cr_s      = cr_r;
    fopen_s   = fopen_r;
    dseen_s   = dseen_r;
    len_s     = len_r;
    ovf_s     = ovf_r;
    cc        = item_byte_r;
    is_eoi    = (item_op_r == ssed_pkg::OP_EOI);
    do_cont   = 1'b0;
    do_lreset = 1'b0;
    bf_en     = 1'b0;
    bf_kind   = LK_OTHER;
    more_cr   = 1'b0;
    go_drain  = 1'b0;
    emit      = 1'b0;
    emit_kind = ssed_pkg::KIND_DATA;
    emit_byte = 8'h00;
    we        = 1'b0;

    // Classify the step
    priority if (!cmd.sel_second && is_eoi) begin
      if (phase_r == PH_NAME) begin
        bf_en   = 1'b1;
        bf_kind = nkind;
      end
      do_lreset = 1'b1;
    end else if (!cmd.sel_second && item_byte_r == CH_LF) begin
      if (phase_r == PH_START) begin
        go_drain = fopen_r;
      end else if (phase_r == PH_NAME) begin
        bf_en   = 1'b1;
        bf_kind = nkind;
      end
      do_lreset = 1'b1;
    end else if (!cmd.sel_second && cr_r) begin
      // replay the stray CR as content, the byte follows next step
      cr_s    = 1'b0;
      cc      = CH_CR;
      do_cont = 1'b1;
      more_cr = 1'b1;
    end else if (item_byte_r == CH_CR) begin
      cr_s = 1'b1;
    end else begin
      do_cont = 1'b1;
    end

    // Line content
    if (do_cont) begin
      unique case (phase_r)
        PH_START: begin
          if (cc == CH_COLON) begin
            phase_s = PH_COMMENT;
          end else begin
            phase_s = PH_NAME;
            cand_s  = fd_cand;
            prog_s  = fd_prog;
          end
        end
        PH_NAME: begin
          if (cc == CH_COLON) begin
            bf_en   = 1'b1;
            bf_kind = nkind;
            lkind_s = nkind;
            phase_s = PH_VALUE;
            space_s = 1'b1;
          end else begin
            cand_s = fd_cand;
            prog_s = fd_prog;
          end
        end
        PH_VALUE: begin
          space_s = 1'b0;
          if (!(space_r && cc == CH_SPACE)) begin
            if (lkind_r == LK_DATA) begin
              emit      = 1'b1;
              emit_byte = cc;
            end else if (lkind_r == LK_EVENT) begin
              if (len_r < LEN_MAX) begin
                we    = 1'b1;
                len_s = len_r + 1'b1;
              end else begin
                ovf_s = 1'b1;
              end
            end
          end
        end
        PH_COMMENT: begin
        end
        default: begin
        end
      endcase
    end

    // Open a field
    if (bf_en) begin
      if (bf_kind == LK_DATA) begin
        if (dseen_r) begin
          emit      = 1'b1;
          emit_byte = CH_LF;
        end
        dseen_s = 1'b1;
        fopen_s = 1'b1;
      end else if (bf_kind == LK_EVENT) begin
        fopen_s = 1'b1;
        len_s   = '0;
        ovf_s   = 1'b0;
      end
    end

    // Return the line state to its start
    if (do_lreset) begin
      phase_s = PH_START;
      prog_s  = 3'd0;
      cand_s  = 2'b11;
      lkind_s = LK_OTHER;
      space_s = 1'b0;
      cr_s    = 1'b0;
    end

    // End of input flushes whatever frame is open
    if (!cmd.sel_second && is_eoi) begin
      go_drain = fopen_s;
      if (!fopen_s) begin
        dseen_s = 1'b0;
        len_s   = '0;
        ovf_s   = 1'b0;
      end
    end

    if (!cmd.sel_second && is_eoi) begin
      emit_last = 1'b0;
    end else if (more_cr) begin
      emit_last = (item_byte_r == CH_CR);
    end else begin
      emit_last = 1'b1;
    end
  end

  assign frame_done = (didx_r == len_r);
  assign slot_free  = !out_vld_r || !out_stall;

  assign st.want_out   = emit;
  assign st.more_cr    = more_cr;
  assign st.go_drain   = go_drain;
  assign st.frame_done = frame_done;
  assign st.slot_free  = slot_free;

  // Select next state: commit a step or advance the drain
  always_comb begin
    phase_nxt = phase_r;
    prog_nxt  = prog_r;
    cand_nxt  = cand_r;
    lkind_nxt = lkind_r;
    space_nxt = space_r;
    cr_nxt    = cr_r;
    fopen_nxt = fopen_r;
    dseen_nxt = dseen_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    didx_nxt  = didx_r;
    if (cmd.act) begin
      phase_nxt = phase_s;
      prog_nxt  = prog_s;
      cand_nxt  = cand_s;
      lkind_nxt = lkind_s;
      space_nxt = space_s;
      cr_nxt    = cr_s;
      fopen_nxt = fopen_s;
      dseen_nxt = dseen_s;
      len_nxt   = len_s;
      ovf_nxt   = ovf_s;
    end else if (cmd.drain_take) begin
      if (frame_done) begin
        fopen_nxt = 1'b0;
        dseen_nxt = 1'b0;
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
        didx_nxt  = '0;
      end else begin
        didx_nxt = didx_r + 1'b1;
      end
    end
  end

  // Prefetch the next drain byte
  always_comb begin
    if (didx_nxt < LEN_MAX) begin
      rd_addr = didx_nxt[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  // Load the output register
  always_comb begin
    out_pay_nxt = out_pay_r;
    out_vld_nxt = out_vld_r && out_stall;
    if (cmd.act && emit) begin
      out_vld_nxt                 = 1'b1;
      out_pay_nxt.kind            = emit_kind;
      out_pay_nxt.out_byte        = emit_byte;
      out_pay_nxt.event_truncated = 1'b0;
      out_pay_nxt.last            = emit_last;
    end else if (cmd.drain_take) begin
      out_vld_nxt = 1'b1;
      if (frame_done) begin
        out_pay_nxt.kind            = ssed_pkg::KIND_FEND;
        out_pay_nxt.out_byte        = 8'h00;
        out_pay_nxt.event_truncated = ovf_r;
        out_pay_nxt.last            = 1'b1;
      end else begin
        out_pay_nxt.kind            = ssed_pkg::KIND_EVENT;
        out_pay_nxt.out_byte        = rd_data_r;
        out_pay_nxt.event_truncated = 1'b0;
        out_pay_nxt.last            = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      prog_r    <= 3'd0;
      cand_r    <= 2'b11;
      lkind_r   <= LK_OTHER;
      space_r   <= 1'b0;
      cr_r      <= 1'b0;
      fopen_r   <= 1'b0;
      dseen_r   <= 1'b0;
      len_r     <= '0;
      ovf_r     <= 1'b0;
      didx_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      prog_r    <= prog_nxt;
      cand_r    <= cand_nxt;
      lkind_r   <= lkind_nxt;
      space_r   <= space_nxt;
      cr_r      <= cr_nxt;
      fopen_r   <= fopen_nxt;
      dseen_r   <= dseen_nxt;
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
      didx_r    <= didx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op_r   <= in_data.operation;
      item_byte_r <= in_data.text_byte;
    end
    out_pay_r <= out_pay_nxt;
  end

  // Event name store: write at the fill point, registered read for the drain
  always_ff @(posedge clk) begin
    if (cmd.act && we) begin
      ev_mem[len_r[AW-1:0]] <= cc;
    end
    rd_data_r <= ev_mem[rd_addr];
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_pay_r;

endmodule

`default_nettype wire

FILE: rtl/sse_stream_decoder.sv
// Top level of the event-stream decoder.
//
// Input channel (in_valid, in_stall, in_data): one beat per text byte, or an
// end-of-input beat that flushes the final frame. Output channel (out_valid,
// out_stall, out_data): data bytes, event name bytes and frame end markers,
// with last set on the final result of each input beat.
// An accepted beat is held in an item register and worked on in the next
// cycle; a result it makes is loaded into the output register when its step
// commits. Plain bytes and line feeds that close no frame need only the first
// step, so the block takes one beat per cycle while the output is not
// stalled. A CR held back before a byte other than LF is replayed as content
// in its own step before that byte. Closing a frame takes the closing beat's
// step, a drain beat per name store byte, and one for the frame end marker.
// Reset (rst_n low, synchronous) returns the parser to line start with no
// frame open; the name store needs no clearing. When the receiver stalls,
// the output register holds its beat and a step that needs the output waits
// with its item held, which stalls the input; beats that make no result
// still pass.
`default_nettype none

module sse_stream_decoder #(
  parameter int EVENT_MAX = ssed_pkg::EVENT_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ssed_pkg::ssed_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ssed_pkg::ssed_out_t     out_data
);

  ssed_pkg::ssed_cmd_t  cmd;
  ssed_pkg::ssed_stat_t st;

  ssed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ssed_dp #(
    .EVENT_MAX (EVENT_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A step and a drain beat never share a cycle
  a_step_xor_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.act && cmd.drain_take))
    else $error("step and drain issued together");

  // Drain beats go only into a free output register
  a_drain_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_take |-> st.slot_free)
    else $error("drain beat with output register busy");

  // Truncation is flagged only on a frame end
  a_trunc_fend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.event_truncated) |-> (out_data.kind == ssed_pkg::KIND_FEND))
    else $error("truncation flag outside frame end");

  // An event name byte is always followed by more of the same frame
  a_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == ssed_pkg::KIND_EVENT) |-> !out_data.last)
    else $error("event name byte marked last");

endmodule

`default_nettype wire

FILE: tb/ssed_tb_pkg.sv
// Scoreboard for the event-stream decoder: predicts results per input beat and checks them.
package ssed_tb_pkg;
  import ssed_pkg::*;

  localparam int NAME_DEPTH = EVENT_MAX_DEF;
  localparam int REPORT_MAX = 10;

  localparam logic       OP_BYTE  = 1'b0;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [31:0] WORD_DATA  = "data";
  localparam logic [39:0] WORD_EVENT = "event";

  typedef enum logic [1:0] {LN_START, LN_NAME, LN_VALUE, LN_COMMENT} line_pos_e;
  typedef enum logic [1:0] {FLD_OTHER, FLD_DATA, FLD_EVENT} field_e;

  class sse_scoreboard;
    ssed_out_t   pending_q[$];
    int unsigned mismatches;

    // parser state of the prediction
    line_pos_e   pos;
    logic [2:0]  name_len;
    logic        may_data;
    logic        may_event;
    field_e      field;
    logic        skip_space;
    logic        cr_held;
    logic        frame_open;
    logic        data_seen;
    logic [7:0]  name_buf[NAME_DEPTH];
    int unsigned name_count;
    logic        name_cut;

    function new();
      clear_line();
      clear_frame();
      mismatches = 0;
    endfunction

    function void clear_line();
      pos        = LN_START;
      name_len   = 3'd0;
      may_data   = 1'b1;
      may_event  = 1'b1;
      field      = FLD_OTHER;
      skip_space = 1'b0;
      cr_held    = 1'b0;
    endfunction

    function void clear_frame();
      frame_open = 1'b0;
      data_seen  = 1'b0;
      name_count = 0;
      name_cut   = 1'b0;
    endfunction

    function void push_result(logic [1:0] k, logic [7:0] b, logic t);
      ssed_out_t r;
      r.kind            = k;
      r.out_byte        = b;
      r.event_truncated = t;
      r.last            = 1'b0;
      pending_q = {pending_q, r};
    endfunction

    // Narrow down which field name the line can still be
    function void track_name(logic [7:0] c);
      if (name_len >= 3'd4) begin
        may_data = 1'b0;
      end else if (c != WORD_DATA[31 - 8 * int'(name_len) -: 8]) begin
        may_data = 1'b0;
      end
      if (name_len >= 3'd5) begin
        may_event = 1'b0;
      end else if (c != WORD_EVENT[39 - 8 * int'(name_len) -: 8]) begin
        may_event = 1'b0;
      end
      if (name_len < 3'd7) name_len++;
    endfunction

    function field_e name_field();
      if (may_data && name_len == 3'd4) return FLD_DATA;
      if (may_event && name_len == 3'd5) return FLD_EVENT;
      return FLD_OTHER;
    endfunction

    function void open_field(field_e f);
      if (f == FLD_DATA) begin
        if (data_seen) push_result(KIND_DATA, CH_LF, 1'b0);
        data_seen  = 1'b1;
        frame_open = 1'b1;
      end else if (f == FLD_EVENT) begin
        frame_open = 1'b1;
        name_count = 0;
        name_cut   = 1'b0;
      end
    endfunction

    // Emit the buffered event name and the frame end marker
    function void close_frame();
      if (!frame_open) return;
      for (int i = 0; i < name_count; i++) push_result(KIND_EVENT, name_buf[i], 1'b0);
      push_result(KIND_FEND, 8'h00, name_cut);
      clear_frame();
    endfunction

    function void take_content(logic [7:0] c);
      case (pos)
        LN_START: begin
          if (c == CH_COLON) begin
            pos = LN_COMMENT;
          end else begin
            pos = LN_NAME;
            track_name(c);
          end
        end
        LN_NAME: begin
          if (c == CH_COLON) begin
            field = name_field();
            open_field(field);
            pos        = LN_VALUE;
            skip_space = 1'b1;
          end else begin
            track_name(c);
          end
        end
        LN_VALUE: begin
          if (skip_space && c == CH_SPACE) begin
            skip_space = 1'b0;
          end else begin
            skip_space = 1'b0;
            if (field == FLD_DATA) begin
              push_result(KIND_DATA, c, 1'b0);
            end else if (field == FLD_EVENT) begin
              if (name_count < NAME_DEPTH) begin
                name_buf[name_count] = c;
                name_count++;
              end else begin
                name_cut = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void end_line();
      if (pos == LN_START) close_frame();
      else if (pos == LN_NAME) open_field(name_field());
      clear_line();
    endfunction

    // Work out the results of one accepted input beat
    function void note_input(ssed_in_t item);
      int unsigned start;
      start = pending_q.size();
      if (item.operation == OP_EOI) begin
        cr_held = 1'b0;
        end_line();
        close_frame();
        clear_line();
        clear_frame();
      end else if (item.text_byte == CH_LF) begin
        end_line();
      end else begin
        if (cr_held) begin
          cr_held = 1'b0;
          take_content(CH_CR);
        end
        if (item.text_byte == CH_CR) cr_held = 1'b1;
        else take_content(item.text_byte);
      end
      // Mark the final result of this beat
      if (pending_q.size() > start) begin
        pending_q[pending_q.size() - 1].last = 1'b1;
      end
    endfunction

    // Compare one accepted result beat with the oldest prediction
    function void check_result(ssed_out_t got);
      ssed_out_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: kind=%0d byte=%02h trunc=%0b last=%0b",
                   got.kind, got.out_byte, got.event_truncated, got.last);
        return;
      end
      want = pending_q.pop_front();
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.event_truncated !== want.event_truncated || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"mismatch: expected kind=%0d byte=%02h trunc=%0b last=%0b,",
                    " got kind=%0d byte=%02h trunc=%0b last=%0b"},
                   want.kind, want.out_byte, want.event_truncated, want.last,
                   got.kind, got.out_byte, got.event_truncated, got.last);
      end
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
// Top of the event-stream decoder testbench: clock, reset, stimulus, receiver and watchdog.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssed_pkg::*;
  import ssed_tb_pkg::*;

  localparam int RANDOM_ITEMS = 350;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AFTER   = 40;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  ssed_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  ssed_out_t out_data;

  sse_scoreboard sb;
  ssed_in_t      stim_q[$];
  int            send_run = 0;
  int            recv_run = 0;
  logic          hold_on = 1'b0;
  logic          held_once = 1'b0;
  int unsigned   results_seen = 0;
  int unsigned   idle_cycles = 0;

  sse_stream_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Draw an idle count, with occasional runs of back-to-back beats
  function automatic int draw_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    if ($urandom_range(0, 11) == 0) return CH_CR;
    do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
    return b;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    ssed_in_t item;
    item.operation = OP_BYTE;
    item.text_byte = b;
    stim_q = {stim_q, item};
  endtask

  task automatic add_eoi();
    ssed_in_t item;
    item.operation = OP_EOI;
    item.text_byte = 8'($urandom_range(0, 255));
    stim_q = {stim_q, item};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Colon, maybe a space, then n value bytes
  task automatic add_value(input int n);
    add_byte(CH_COLON);
    if ($urandom_range(0, 2) != 0) add_byte(CH_SPACE);
    for (int i = 0; i < n; i++) add_byte(value_byte());
  endtask

  task automatic add_event_line(input int n);
    add_text("event");
    add_value(n);
  endtask

  task automatic add_line_end();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      add_byte(CH_LF);
    end else if (r < 19) begin
      add_byte(CH_CR);
      add_byte(CH_LF);
    end else begin
      add_byte(CH_CR);
      add_byte(CH_CR);
      add_byte(CH_LF);
    end
  endtask

  // Append one random line, mostly well-formed fields
  task automatic add_random_line();
    int pick;
    int n;
    pick = $urandom_range(0, 15);
    if (pick <= 4) begin
      add_text("data");
      if ($urandom_range(0, 5) != 0) add_value($urandom_range(0, 8));
    end else if (pick <= 6) begin
      if ($urandom_range(0, 5) == 0) add_text("event");
      else add_event_line(($urandom_range(0, 3) == 0) ? $urandom_range(28, 40)
                                                       : $urandom_range(0, 6));
    end else if (pick == 7) begin
      add_byte(CH_COLON);
      for (int i = 0; i < $urandom_range(0, 6); i++) add_byte(value_byte());
    end else if (pick == 8) begin
      case ($urandom_range(0, 5))
        0: add_text("id");
        1: add_text("retry");
        2: add_text("dat");
        3: add_text("datas");
        4: add_text("even");
        default: add_text("eventx");
      endcase
      if ($urandom_range(0, 3) != 0) add_value($urandom_range(0, 4));
    end else if (pick == 9) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) add_byte(value_byte());
      add_value($urandom_range(0, 4));
    end else if (pick <= 12) begin
      // blank line: nothing before the line end
    end else if (pick == 13) begin
      add_eoi();
      return;
    end else if (pick == 14) begin
      add_text("data");
      add_value($urandom_range(0, 4));
      add_eoi();
      return;
    end else begin
      add_byte(8'($urandom_range(0, 255)));
      return;
    end
    add_line_end();
  endtask

  task automatic build_stimulus();
    // blank line with no frame, empty comment, event name 0xff
    add_byte(CH_LF);
    add_text(":\n");
    add_text("event:");
    add_byte(8'hFF);
    add_byte(CH_LF);
    // data with skipped space, byte 0x00, stray CR then CR LF
    add_text("data: ");
    add_byte(8'h00);
    add_byte(CH_CR);
    add_byte(CH_CR);
    add_byte(CH_LF);
    // bare data line adds an empty line, blank line closes the frame
    add_text("data\n\n");
    add_eoi();
    // random part, opened by an over-long event name
    add_event_line(36);
    add_byte(CH_LF);
    add_byte(CH_LF);
    while (stim_q.size() < RANDOM_ITEMS) add_random_line();
    add_eoi();
  endtask

  // Offer one input beat and hold it until accepted
  task automatic drive_item(input ssed_in_t item);
    int gap;
    gap = hold_on ? 0 : draw_gap(send_run);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(item);
  endtask

  // Stimulus and end of run
  initial begin
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    build_stimulus();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (stim_q.size() > 0) drive_item(stim_q.pop_front());
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random stall per result, one long hold-off to fill the block
  initial begin
    int k;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && results_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_on   = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on   = 1'b0;
        out_stall <= 1'b0;
      end else begin
        k = draw_gap(recv_run);
        if (k > 0) begin
          out_stall <= 1'b1;
          repeat (k) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
      results_seen++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

endmodule
